/* hw/rtl/assert_macros.svh */
// assertion macros used by the port level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked at every rising clock edge out of reset
`define HSV_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hsv to rgb assertion failed");

// condition that must never hold, also checked during reset
`define HSV_ASSERT_NEVER(lbl, clk, cond) \
   lbl: assert property (@(posedge clk) !(cond)) \
      else $error("hsv to rgb forbidden condition seen");

`endif

/* hw/rtl/hsvrgb_pkg.sv */
// shared types and constants of the hsv to rgb converter
package hsvrgb_pkg;

   localparam int CHAN_BITS    = 8;
   localparam int HUE_BITS     = 9;
   localparam int SECTOR_DEG   = 60;
   localparam int SECTOR_BITS  = 4;
   localparam int WEIGHT_BITS  = 6;
   localparam int SECTOR_LAST  = ((1 << HUE_BITS) - 1) / SECTOR_DEG;
   localparam int PROD_BITS    = 2 * CHAN_BITS;
   localparam int DIV_N_BITS   = CHAN_BITS + WEIGHT_BITS;
   localparam int DIV_SHIFT    = DIV_N_BITS;
   localparam int DIV_RECIP    = (1 << DIV_SHIFT) / SECTOR_DEG;
   localparam int RECIP_BITS   = DIV_N_BITS - 5;
   localparam int DIV_EST_BITS = DIV_N_BITS + RECIP_BITS;

   localparam logic [SECTOR_BITS-1:0] SEC_RED_YELLOW    = SECTOR_BITS'(0);
   localparam logic [SECTOR_BITS-1:0] SEC_YELLOW_GREEN  = SECTOR_BITS'(1);
   localparam logic [SECTOR_BITS-1:0] SEC_GREEN_CYAN    = SECTOR_BITS'(2);
   localparam logic [SECTOR_BITS-1:0] SEC_CYAN_BLUE     = SECTOR_BITS'(3);
   localparam logic [SECTOR_BITS-1:0] SEC_BLUE_MAGENTA  = SECTOR_BITS'(4);

   typedef struct packed {
      logic [HUE_BITS-1:0]  hue_degrees;
      logic [CHAN_BITS-1:0] sat_level;
      logic [CHAN_BITS-1:0] val_level;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red_out;
      logic [CHAN_BITS-1:0] green_out;
      logic [CHAN_BITS-1:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [DIV_N_BITS-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic                 valid;
      logic [CHAN_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

/* hw/rtl/hsv_to_rgb_converter_top.sv */
// hsv to rgb converter: six stage pipeline, one color per clock
//
//  channel   ports                     direction  handshake
//  request   start, busy, req_data     in         accepted when start and not busy
//  response  rsp_valid, rsp_data       out        one cycle strobe, no backpressure
//
// one beat per clock sustained; busy stays low, the pipeline never stalls
// each result is registered through stages 1 to 3, the divider and the output
// register; the path holds the chroma divide, weight multiply and divide by sixty
// synchronous reset clears only the stage valid bits; beats in flight are dropped
module hsv_to_rgb_converter_top import hsvrgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // stage 1: saturation times value, sector index
   logic [PROD_BITS-1:0]   prod_in;
   logic [SECTOR_BITS-1:0] sector_in;
   logic                   s1_valid_ff;
   logic [PROD_BITS-1:0]   s1_prod_ff;
   logic [SECTOR_BITS-1:0] s1_sector_ff;
   logic [HUE_BITS-1:0]    s1_hue_ff;
   logic [CHAN_BITS-1:0]   s1_val_ff;

   // stage 2: chroma and secondary weight
   logic [PROD_BITS:0]     chroma_sum;
   logic [CHAN_BITS-1:0]   chroma_in;
   logic [HUE_BITS-1:0]    pair_base;
   logic [HUE_BITS-1:0]    hue_rem;
   logic [HUE_BITS-1:0]    hue_dist;
   logic [WEIGHT_BITS-1:0] weight_in;
   logic                   s2_valid_ff;
   logic [CHAN_BITS-1:0]   s2_chroma_ff;
   logic [WEIGHT_BITS-1:0] s2_weight_ff;
   logic [SECTOR_BITS-1:0] s2_sector_ff;
   logic [CHAN_BITS-1:0]   s2_val_ff;

   // stage 3: chroma times weight, offset
   logic [DIV_N_BITS-1:0]  scaled_in;
   logic                   s3_valid_ff;
   logic [DIV_N_BITS-1:0]  s3_scaled_ff;
   logic [CHAN_BITS-1:0]   s3_chroma_ff;
   logic [CHAN_BITS-1:0]   s3_offset_ff;
   logic [SECTOR_BITS-1:0] s3_sector_ff;

   // stages 4 and 5: side data next to the divider
   logic [CHAN_BITS-1:0]   s4_chroma_ff;
   logic [CHAN_BITS-1:0]   s4_offset_ff;
   logic [SECTOR_BITS-1:0] s4_sector_ff;
   logic [CHAN_BITS-1:0]   s5_chroma_ff;
   logic [CHAN_BITS-1:0]   s5_offset_ff;
   logic [SECTOR_BITS-1:0] s5_sector_ff;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   // stage 6: placement and offset add
   logic [CHAN_BITS-1:0]   red_comp;
   logic [CHAN_BITS-1:0]   green_comp;
   logic [CHAN_BITS-1:0]   blue_comp;
   rsp_type                rsp_in;
   logic                   out_valid_ff;
   rsp_type                out_data_ff;

   assign busy = 1'b0;

   assign prod_in = PROD_BITS'(req_data.sat_level) * PROD_BITS'(req_data.val_level);

   always_comb begin
      sector_in = '0;
      for (int i = 1; i <= SECTOR_LAST; i++) begin
         if (req_data.hue_degrees >= HUE_BITS'(i * SECTOR_DEG)) begin
            sector_in = sector_in + SECTOR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_prod_ff   <= prod_in;
      s1_sector_ff <= sector_in;
      s1_hue_ff    <= req_data.hue_degrees;
      s1_val_ff    <= req_data.val_level;
   end

   // exact floor divide by the all ones channel maximum
   assign chroma_sum = (PROD_BITS + 1)'(s1_prod_ff)
                     + (PROD_BITS + 1)'(s1_prod_ff >> CHAN_BITS)
                     + (PROD_BITS + 1)'(1);
   assign chroma_in  = chroma_sum[CHAN_BITS +: CHAN_BITS];

   assign pair_base = HUE_BITS'(s1_sector_ff >> 1) * HUE_BITS'(2 * SECTOR_DEG);
   assign hue_rem   = s1_hue_ff - pair_base;

   always_comb begin
      if (hue_rem >= HUE_BITS'(SECTOR_DEG)) begin
         hue_dist = hue_rem - HUE_BITS'(SECTOR_DEG);
      end else begin
         hue_dist = HUE_BITS'(SECTOR_DEG) - hue_rem;
      end
   end

   assign weight_in = WEIGHT_BITS'(HUE_BITS'(SECTOR_DEG) - hue_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_chroma_ff <= chroma_in;
      s2_weight_ff <= weight_in;
      s2_sector_ff <= s1_sector_ff;
      s2_val_ff    <= s1_val_ff;
   end

   assign scaled_in = DIV_N_BITS'(s2_chroma_ff) * DIV_N_BITS'(s2_weight_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_scaled_ff <= scaled_in;
      s3_chroma_ff <= s2_chroma_ff;
      s3_offset_ff <= s2_val_ff - s2_chroma_ff;
      s3_sector_ff <= s2_sector_ff;
   end

   assign div_req.valid    = s3_valid_ff;
   assign div_req.dividend = s3_scaled_ff;

   hsvrgb_div60 u_div60 (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      s4_chroma_ff <= s3_chroma_ff;
      s4_offset_ff <= s3_offset_ff;
      s4_sector_ff <= s3_sector_ff;
      s5_chroma_ff <= s4_chroma_ff;
      s5_offset_ff <= s4_offset_ff;
      s5_sector_ff <= s4_sector_ff;
   end

   always_comb begin
      case (s5_sector_ff)
         SEC_RED_YELLOW: begin
            red_comp   = s5_chroma_ff;
            green_comp = div_rsp.quotient;
            blue_comp  = '0;
         end
         SEC_YELLOW_GREEN: begin
            red_comp   = div_rsp.quotient;
            green_comp = s5_chroma_ff;
            blue_comp  = '0;
         end
         SEC_GREEN_CYAN: begin
            red_comp   = '0;
            green_comp = s5_chroma_ff;
            blue_comp  = div_rsp.quotient;
         end
         SEC_CYAN_BLUE: begin
            red_comp   = '0;
            green_comp = div_rsp.quotient;
            blue_comp  = s5_chroma_ff;
         end
         SEC_BLUE_MAGENTA: begin
            red_comp   = div_rsp.quotient;
            green_comp = '0;
            blue_comp  = s5_chroma_ff;
         end
         default: begin
            red_comp   = s5_chroma_ff;
            green_comp = '0;
            blue_comp  = div_rsp.quotient;
         end
      endcase
   end

   assign rsp_in.red_out   = red_comp + s5_offset_ff;
   assign rsp_in.green_out = green_comp + s5_offset_ff;
   assign rsp_in.blue_out  = blue_comp + s5_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_rsp.valid;
      end
      out_data_ff <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* hw/rtl/hsvrgb_div60.sv */
// two stage divide by sixty: reciprocal estimate, then one correction step
module hsvrgb_div60 import hsvrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_EST_BITS-1:0] est_prod;
   logic [CHAN_BITS-1:0]    est_in;
   logic                    est_valid_ff;
   logic [DIV_N_BITS-1:0]   est_num_ff;
   logic [CHAN_BITS-1:0]    est_quot_ff;
   logic [DIV_N_BITS-1:0]   est_back;
   logic [DIV_N_BITS-1:0]   est_rem;
   logic [CHAN_BITS-1:0]    quot_in;
   logic                    quot_valid_ff;
   logic [CHAN_BITS-1:0]    quot_ff;

   // estimate is exact or one low
   assign est_prod = DIV_EST_BITS'(div_req.dividend) * DIV_EST_BITS'(DIV_RECIP);
   assign est_in   = est_prod[DIV_SHIFT +: CHAN_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff <= 1'b0;
      end else begin
         est_valid_ff <= div_req.valid;
      end
      est_num_ff  <= div_req.dividend;
      est_quot_ff <= est_in;
   end

   assign est_back = DIV_N_BITS'(est_quot_ff) * DIV_N_BITS'(SECTOR_DEG);
   assign est_rem  = est_num_ff - est_back;

   always_comb begin
      quot_in = est_quot_ff;
      if (est_rem >= DIV_N_BITS'(SECTOR_DEG)) begin
         quot_in = est_quot_ff + CHAN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_valid_ff <= 1'b0;
      end else begin
         quot_valid_ff <= est_valid_ff;
      end
      quot_ff <= quot_in;
   end

   assign div_rsp.valid    = quot_valid_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

/* hw/rtl/hsvrgb_checker.sv */
// port level checker for the hsv to rgb converter, with its bind
`include "assert_macros.svh"

module hsvrgb_checker import hsvrgb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   `HSV_ASSERT_NEVER(a_never_busy, clock, busy)

   `HSV_ASSERT_CLK(a_beat_gives_result, clock, reset, (start && !busy) |-> ##6 rsp_valid)

   `HSV_ASSERT_CLK(a_result_has_beat, clock, reset, rsp_valid |-> $past(start && !busy, 6))

   `HSV_ASSERT_CLK(a_peak_is_value, clock, reset, rsp_valid |-> (rsp_data.red_out == $past(req_data.val_level, 6) || rsp_data.green_out == $past(req_data.val_level, 6) || rsp_data.blue_out == $past(req_data.val_level, 6)))

   `HSV_ASSERT_CLK(a_gray_when_unsaturated, clock, reset, (rsp_valid && $past(req_data.sat_level, 6) == '0) |-> (rsp_data.red_out == rsp_data.green_out && rsp_data.green_out == rsp_data.blue_out))

endmodule

bind hsv_to_rgb_converter_top hsvrgb_checker u_hsvrgb_checker (.*);

/* verif/hsv_to_rgb_converter_top_tb.sv */
// testbench of the hsv to rgb converter: directed table, random pixels, scoreboard check
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top_tb;
   import hsvrgb_pkg::*;

   localparam int unsigned FULL_SCALE = (1 << CHAN_BITS) - 1;
   localparam int unsigned HUE_TOP    = (1 << HUE_BITS) - 1;
   localparam int          RANDOM_PIXELS = 600;

   typedef struct {
      req_type pixel;
      bit      known;
      rsp_type rgb;
   } table_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type       rgb_expected_q[$];
   table_row_type directed_rows[$];
   int            error_count;

   hsv_to_rgb_converter_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic rsp_type predict_rgb(input req_type px);
      int unsigned            hue, s, v, c, x, m, r, g, b, rem, hue_gap;
      logic [SECTOR_BITS-1:0] sec;
      rsp_type                rgb;
      hue     = px.hue_degrees;
      s       = px.sat_level;
      v       = px.val_level;
      c       = (v * s) / FULL_SCALE;
      sec     = SECTOR_BITS'(hue / SECTOR_DEG);
      rem     = hue % (2 * SECTOR_DEG);
      hue_gap = (rem >= SECTOR_DEG) ? (rem - SECTOR_DEG) : (SECTOR_DEG - rem);
      x       = (c * (SECTOR_DEG - hue_gap)) / SECTOR_DEG;
      m       = v - c;
      case (sec)
         SEC_RED_YELLOW: begin
            r = c; g = x; b = 0;
         end
         SEC_YELLOW_GREEN: begin
            r = x; g = c; b = 0;
         end
         SEC_GREEN_CYAN: begin
            r = 0; g = c; b = x;
         end
         SEC_CYAN_BLUE: begin
            r = 0; g = x; b = c;
         end
         SEC_BLUE_MAGENTA: begin
            r = x; g = 0; b = c;
         end
         default: begin
            r = c; g = 0; b = x;
         end
      endcase
      rgb.red_out   = CHAN_BITS'(r + m);
      rgb.green_out = CHAN_BITS'(g + m);
      rgb.blue_out  = CHAN_BITS'(b + m);
      return rgb;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_row(input int unsigned hue, input int unsigned s, input int unsigned v,
                          input bit known, input int unsigned r, input int unsigned g,
                          input int unsigned b);
      table_row_type row;
      row.pixel.hue_degrees = HUE_BITS'(hue);
      row.pixel.sat_level   = CHAN_BITS'(s);
      row.pixel.val_level   = CHAN_BITS'(v);
      row.known             = known;
      row.rgb.red_out       = CHAN_BITS'(r);
      row.rgb.green_out     = CHAN_BITS'(g);
      row.rgb.blue_out      = CHAN_BITS'(b);
      directed_rows.push_back(row);
   endtask

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_pixel(input req_type px, input rsp_type rgb);
      start    = 1'b1;
      req_data = px;
      @(posedge clock);
      while (busy) @(posedge clock);
      rgb_expected_q.push_back(rgb);
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (rgb_expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic req_type random_pixel();
      req_type     px;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         px.hue_degrees = HUE_BITS'(SECTOR_DEG * $urandom_range(1, 6) - $urandom_range(0, 1));
      else if (pick < 22)
         px.hue_degrees = HUE_BITS'($urandom_range(360, HUE_TOP));
      else
         px.hue_degrees = HUE_BITS'($urandom_range(0, 359));
      pick = $urandom_range(0, 99);
      if (pick < 12)
         px.sat_level = '0;
      else if (pick < 27)
         px.sat_level = CHAN_BITS'(FULL_SCALE);
      else
         px.sat_level = CHAN_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10)
         px.val_level = '0;
      else if (pick < 25)
         px.val_level = CHAN_BITS'(FULL_SCALE);
      else
         px.val_level = CHAN_BITS'($urandom);
      return px;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (rgb_expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                                      rsp_data.red_out, rsp_data.green_out,
                                      rsp_data.blue_out));
         end else begin
            want = rgb_expected_q.pop_front();
            if (rsp_data.red_out !== want.red_out)
               report_mismatch($sformatf("red_out %0d, expected %0d",
                                         rsp_data.red_out, want.red_out));
            if (rsp_data.green_out !== want.green_out)
               report_mismatch($sformatf("green_out %0d, expected %0d",
                                         rsp_data.green_out, want.green_out));
            if (rsp_data.blue_out !== want.blue_out)
               report_mismatch($sformatf("blue_out %0d, expected %0d",
                                         rsp_data.blue_out, want.blue_out));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("** hsv_to_rgb_converter_top: FAILED **");
      $finish;
   end

   initial begin
      req_type px;
      int      sent;
      int      burst_len;
      bit      paused;
      error_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // primaries and secondaries at full scale
      add_row(0,   255, 255, 1, 255, 0,   0);
      add_row(60,  255, 255, 1, 255, 255, 0);
      add_row(120, 255, 255, 1, 0,   255, 0);
      add_row(180, 255, 255, 1, 0,   255, 255);
      add_row(240, 255, 255, 1, 0,   0,   255);
      add_row(300, 255, 255, 1, 255, 0,   255);
      // gray when saturation or value is zero
      add_row(0,   0,   255, 1, 255, 255, 255);
      add_row(200, 0,   77,  1, 77,  77,  77);
      add_row(359, 255, 0,   1, 0,   0,   0);
      add_row(0,   0,   0,   1, 0,   0,   0);
      // hue past 359 falls to the default placement; later rows hit sector edges and other hues
      add_row(360, 255, 255, 1, 255, 0,   0);
      add_row(420, 255, 255, 1, 255, 0,   255);
      add_row(511, 255, 255, 0, 0, 0, 0);
      add_row(479, 170, 200, 0, 0, 0, 0);
      add_row(359, 255, 255, 0, 0, 0, 0);
      add_row(59,  255, 255, 0, 0, 0, 0);
      add_row(119, 128, 255, 0, 0, 0, 0);
      add_row(179, 255, 128, 0, 0, 0, 0);
      add_row(239, 1,   255, 0, 0, 0, 0);
      add_row(299, 255, 1,   0, 0, 0, 0);
      add_row(30,  127, 254, 0, 0, 0, 0);
      add_row(256, 170, 85,  0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].known)
            send_pixel(directed_rows[i].pixel, directed_rows[i].rgb);
         else
            send_pixel(directed_rows[i].pixel, predict_rgb(directed_rows[i].pixel));
         if (i % 7 == 3) idle_cycles($urandom_range(1, 4));
      end
      drain_results();

      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 7));
         burst_len = $urandom_range(1, 40);
         while (burst_len > 0 && sent < RANDOM_PIXELS) begin
            px = random_pixel();
            send_pixel(px, predict_rgb(px));
            sent++;
            burst_len--;
         end
         if (!paused && sent >= RANDOM_PIXELS / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end

      drain_results();
      repeat (12) @(negedge clock);
      if (error_count == 0)
         $display("** hsv_to_rgb_converter_top: PASSED **");
      else
         $display("** hsv_to_rgb_converter_top: FAILED **");
      $finish;
   end

endmodule
